### design/prgc_pkg.sv
package prgc_pkg;

  localparam int COEF_W  = 16;
  localparam int ERR_W   = COEF_W + 1;
  localparam int DIFF_W  = COEF_W + 2;
  localparam int ACC_W   = 32;
  localparam int PROD_W  = ACC_W + COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int DIV_STEPS = PROD_W / 2;
  localparam int CNT_W   = $clog2(DIV_STEPS);
  localparam int IDX_W   = 4;

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_PROP_NUM  = 4'd0;
  localparam logic [IDX_W-1:0] REG_PROP_DEN  = 4'd1;
  localparam logic [IDX_W-1:0] REG_INTEG_NUM = 4'd2;
  localparam logic [IDX_W-1:0] REG_INTEG_DEN = 4'd3;
  localparam logic [IDX_W-1:0] REG_DERIV_NUM = 4'd4;
  localparam logic [IDX_W-1:0] REG_DERIV_DEN = 4'd5;
  localparam logic [IDX_W-1:0] REG_UPPER     = 4'd6;
  localparam logic [IDX_W-1:0] REG_LOWER     = 4'd7;

  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  x;
    logic signed [COEF_W-1:0] num;
    logic signed [COEF_W-1:0] den;
  } prgc_md_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] quot;
  } prgc_md_rsp_t;

endpackage

### design/prgc_muldiv.sv
module prgc_muldiv (
  input  logic                   clk,
  input  logic                   rst_n,
  input  prgc_pkg::prgc_md_req_t req,
  output prgc_pkg::prgc_md_rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;
  localparam logic [prgc_pkg::CNT_W-1:0] LAST_STEP =
    prgc_pkg::CNT_W'(prgc_pkg::DIV_STEPS - 1);

  logic [1:0]                          state_r;
  logic [prgc_pkg::CNT_W-1:0]          cnt_r;
  logic signed [prgc_pkg::PROD_W-1:0]  prod_r;
  logic [prgc_pkg::PROD_W-1:0]         quo_r, quo_nxt;
  logic [prgc_pkg::COEF_W:0]           rem_r, rem_nxt;
  logic [prgc_pkg::COEF_W:0]           dmag_r;
  logic                                zero_r, dneg_r, neg_r;
  logic signed [prgc_pkg::PROD_W-1:0]  quo_s;

  // two restoring steps per cycle
  always_comb begin
    logic [prgc_pkg::COEF_W+1:0] rem_s;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < 2; k++) begin
      rem_s   = {rem_nxt, quo_nxt[prgc_pkg::PROD_W-1]};
      quo_nxt = {quo_nxt[prgc_pkg::PROD_W-2:0], 1'b0};
      if (rem_s >= {1'b0, dmag_r}) begin
        rem_s      = rem_s - {1'b0, dmag_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = rem_s[prgc_pkg::COEF_W:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_DIV;
          cnt_r   <= '0;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LAST_STEP) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && req.start) begin
      prod_r <= req.x * req.num;
      zero_r <= (req.den == '0);
      dneg_r <= req.den[prgc_pkg::COEF_W-1];
      if (req.den[prgc_pkg::COEF_W-1]) begin
        dmag_r <= -{req.den[prgc_pkg::COEF_W-1], req.den};
      end else begin
        dmag_r <= {1'b0, req.den};
      end
    end
    if (state_r == S_MUL) begin
      neg_r <= prod_r[prgc_pkg::PROD_W-1] ^ dneg_r;
      quo_r <= prod_r[prgc_pkg::PROD_W-1] ? -prod_r : prod_r;
      rem_r <= '0;
    end
    if (state_r == S_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo_s = quo_r;

  always_comb begin
    rsp.done = (state_r == S_DONE);
    if (zero_r) begin
      rsp.quot = '0;
    end else if (neg_r) begin
      rsp.quot = -quo_s;
    end else begin
      rsp.quot = quo_s;
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> $past(state_r) == S_DIV)
    else $error("result without a finished division");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r <= LAST_STEP)
    else $error("division step count overran");

  a_mul_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |=> (state_r == S_DIV && cnt_r == '0))
    else $error("division did not start after the product");
`endif

endmodule

### design/pid_rational_gain_controller_unit.sv
// PID controller with rational gains, integrator windup reset and output clamp.
// Input channel (in_valid/in_ready) takes one request of measured and target;
// the result channel (out_valid/out_ready) returns one drive value per request.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// eight gain and limit registers; it is always ready and is meant to be used
// only while no request is in flight. A write to a listed register restarts
// the derivative history and clears the integrator; other indexes are ignored.
// Each request runs P, I and D through one shared multiplier and a two bit
// per cycle divider, one term after another; a new request is accepted only
// once the previous one has been loaded into the output register.
// The output register frees in_ready while a drive value waits; when the
// receiver stalls, the next request finishes its terms and waits before the
// clamp until the output register is free.
// Reset (rst_n low, synchronous) restores default gains (all terms off),
// full-range limits, clears the integrator and marks the next request first.
module pid_rational_gain_controller_unit #(
  parameter int WINDUP_LIMIT = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_measured,
  input  logic [15:0] in_target,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_drive,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_CLAMP = 3'd3;

  localparam logic [1:0] T_PROP  = 2'd0;
  localparam logic [1:0] T_INTEG = 2'd1;
  localparam logic [1:0] T_DERIV = 2'd2;

  localparam logic signed [prgc_pkg::ACC_W-1:0] WL_POS = prgc_pkg::ACC_W'(WINDUP_LIMIT);
  localparam logic signed [prgc_pkg::ACC_W-1:0] WL_NEG = -WL_POS;

  logic [2:0] state_r;
  logic [1:0] term_r;
  logic       first_r;
  logic       out_valid_r;
  logic [15:0] out_drive_r;

  logic signed [15:0] pnum_r, pden_r, inum_r, iden_r, dnum_r, dden_r;
  logic signed [15:0] upper_r, lower_r;

  logic signed [prgc_pkg::ERR_W-1:0]  err_r, prev_r;
  logic signed [prgc_pkg::DIFF_W-1:0] diff_r;
  logic signed [prgc_pkg::ACC_W-1:0]  accum_r, acc_use_r;
  logic signed [prgc_pkg::SUM_W-1:0]  sum_r;

  logic signed [prgc_pkg::ERR_W-1:0]  err_nxt, prev_eff;
  logic signed [prgc_pkg::DIFF_W-1:0] diff_nxt;
  logic signed [prgc_pkg::ACC_W-1:0]  acc_eff, acc_use_nxt;
  logic signed [prgc_pkg::SUM_W-1:0]  up_ext, lo_ext, clamp_hi, clamp_v;

  logic in_fire, cfg_we, out_load;

  prgc_pkg::prgc_md_req_t md_req;
  prgc_pkg::prgc_md_rsp_t md_rsp;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign out_load  = (state_r == S_CLAMP) && (!out_valid_r || out_ready);

  // error, derivative difference and windup check at acceptance
  always_comb begin
    err_nxt  = {in_target[15], in_target} - {in_measured[15], in_measured};
    prev_eff = first_r ? err_nxt : prev_r;
    diff_nxt = {err_nxt[prgc_pkg::ERR_W-1], err_nxt} - {prev_eff[prgc_pkg::ERR_W-1], prev_eff};
    acc_eff  = first_r ? '0 : accum_r;
    if (acc_eff > WL_POS || acc_eff < WL_NEG) begin
      acc_use_nxt = '0;
    end else begin
      acc_use_nxt = acc_eff;
    end
  end

  always_comb begin
    md_req.start = (state_r == S_START);
    unique case (term_r)
      T_PROP: begin
        md_req.x   = {{(prgc_pkg::ACC_W - prgc_pkg::ERR_W){err_r[prgc_pkg::ERR_W-1]}}, err_r};
        md_req.num = pnum_r;
        md_req.den = pden_r;
      end
      T_INTEG: begin
        md_req.x   = acc_use_r;
        md_req.num = inum_r;
        md_req.den = iden_r;
      end
      default: begin
        md_req.x   = {{(prgc_pkg::ACC_W - prgc_pkg::DIFF_W){diff_r[prgc_pkg::DIFF_W-1]}},
                      diff_r};
        md_req.num = dnum_r;
        md_req.den = dden_r;
      end
    endcase
  end

  prgc_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (md_req),
    .rsp   (md_rsp)
  );

  // upper clamp first, then lower
  always_comb begin
    up_ext   = {{(prgc_pkg::SUM_W - 16){upper_r[15]}}, upper_r};
    lo_ext   = {{(prgc_pkg::SUM_W - 16){lower_r[15]}}, lower_r};
    clamp_hi = (sum_r > up_ext) ? up_ext : sum_r;
    clamp_v  = (clamp_hi < lo_ext) ? lo_ext : clamp_hi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      term_r      <= T_PROP;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
      accum_r     <= '0;
      prev_r      <= '0;
      pnum_r      <= 16'sd0;
      pden_r      <= 16'sd1;
      inum_r      <= 16'sd0;
      iden_r      <= 16'sd1;
      dnum_r      <= 16'sd0;
      dden_r      <= 16'sd1;
      upper_r     <= 16'sh7fff;
      lower_r     <= 16'sh8000;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            term_r  <= T_PROP;
            state_r <= S_START;
          end
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (md_rsp.done) begin
            if (term_r == T_DERIV) begin
              state_r <= S_CLAMP;
            end else begin
              term_r  <= term_r + 1'b1;
              state_r <= S_START;
            end
          end
        end
        S_CLAMP: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            accum_r     <= acc_use_r + {{(prgc_pkg::ACC_W - prgc_pkg::ERR_W)
                                         {err_r[prgc_pkg::ERR_W-1]}}, err_r};
            prev_r      <= err_r;
            first_r     <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          prgc_pkg::REG_PROP_NUM:  pnum_r  <= cfg_data;
          prgc_pkg::REG_PROP_DEN:  pden_r  <= cfg_data;
          prgc_pkg::REG_INTEG_NUM: inum_r  <= cfg_data;
          prgc_pkg::REG_INTEG_DEN: iden_r  <= cfg_data;
          prgc_pkg::REG_DERIV_NUM: dnum_r  <= cfg_data;
          prgc_pkg::REG_DERIV_DEN: dden_r  <= cfg_data;
          prgc_pkg::REG_UPPER:     upper_r <= cfg_data;
          prgc_pkg::REG_LOWER:     lower_r <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= prgc_pkg::REG_LOWER) begin
          first_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      err_r     <= err_nxt;
      diff_r    <= diff_nxt;
      acc_use_r <= acc_use_nxt;
      sum_r     <= '0;
    end else if (state_r == S_WAIT && md_rsp.done) begin
      sum_r <= sum_r + {{(prgc_pkg::SUM_W - prgc_pkg::PROD_W){md_rsp.quot[prgc_pkg::PROD_W-1]}},
                        md_rsp.quot};
    end
    if (out_load) begin
      out_drive_r <= clamp_v[15:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.done |-> state_r == S_WAIT)
    else $error("term result arrived outside the wait state");

  a_out_from_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_CLAMP)
    else $error("output raised without a clamp step");

  a_drive_in_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && upper_r >= lower_r) |=>
      ($signed(out_drive_r) <= $past(upper_r) && $signed(out_drive_r) >= $past(lower_r)))
    else $error("drive outside the configured limits");

  a_first_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !cfg_we) |=> !first_r)
    else $error("first request flag still set after a request");
`endif

endmodule

### dv/tb_pid_rational_gain_controller_unit.sv
module tb_pid_rational_gain_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDUP      = 4096;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_measured = '0;
  logic [15:0] in_target = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_drive;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int          stuck_cycles = 0;
  int          reg_writes = 0;
  int          settings_applied = 0;
  logic [15:0] setting [16];

  always #10 clk = ~clk;

  pid_rational_gain_controller_unit #(
    .WINDUP_LIMIT(WINDUP)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_measured(in_measured),
    .in_target  (in_target),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_drive  (out_drive),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  class drive_predictor;
    logic signed [15:0] gain [16];
    longint             integ_sum;
    longint             prev_err;
    bit                 first_pending;
    logic [15:0]        expected_drive [$];
    int                 mismatches;
    int                 samples;
    int                 drives_checked;
    int                 windup_clears;

    function new();
      gain[prgc_pkg::REG_PROP_NUM]  = 16'sd0;
      gain[prgc_pkg::REG_PROP_DEN]  = 16'sd1;
      gain[prgc_pkg::REG_INTEG_NUM] = 16'sd0;
      gain[prgc_pkg::REG_INTEG_DEN] = 16'sd1;
      gain[prgc_pkg::REG_DERIV_NUM] = 16'sd0;
      gain[prgc_pkg::REG_DERIV_DEN] = 16'sd1;
      gain[prgc_pkg::REG_UPPER]     = 16'sh7fff;
      gain[prgc_pkg::REG_LOWER]     = 16'sh8000;
      integ_sum = 0;
      prev_err = 0;
      first_pending = 1'b1;
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] data);
      // unlisted indexes leave everything alone, history included
      if (idx <= prgc_pkg::REG_LOWER) begin
        gain[idx] = data;
        first_pending = 1'b1;
      end
    endfunction

    function longint scaled(longint x, logic signed [15:0] num, logic signed [15:0] den);
      if (den == 0) return 0;
      return (x * longint'(num)) / longint'(den);
    endfunction

    function void take_sample(logic [15:0] measured, logic [15:0] target);
      longint err;
      longint drive;
      err = longint'($signed(target)) - longint'($signed(measured));
      if (first_pending) begin
        prev_err = err;
        integ_sum = 0;
        first_pending = 1'b0;
      end
      if (integ_sum > WINDUP || integ_sum < -WINDUP) begin
        integ_sum = 0;
        windup_clears++;
      end
      drive = scaled(err, gain[prgc_pkg::REG_PROP_NUM], gain[prgc_pkg::REG_PROP_DEN])
            + scaled(integ_sum, gain[prgc_pkg::REG_INTEG_NUM], gain[prgc_pkg::REG_INTEG_DEN])
            + scaled(err - prev_err, gain[prgc_pkg::REG_DERIV_NUM],
                     gain[prgc_pkg::REG_DERIV_DEN]);
      // upper clamp first, so crossed limits end on the lower one
      if (drive > longint'(gain[prgc_pkg::REG_UPPER])) drive = longint'(gain[prgc_pkg::REG_UPPER]);
      if (drive < longint'(gain[prgc_pkg::REG_LOWER])) drive = longint'(gain[prgc_pkg::REG_LOWER]);
      prev_err = err;
      integ_sum = longint'(int'(integ_sum + err));
      expected_drive.push_back(drive[15:0]);
      samples++;
    endfunction

    function void compare_drive(logic [15:0] got);
      logic [15:0] want;
      drives_checked++;
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] drive %0d with no request outstanding", $realtime, $signed(got));
        return;
      end
      want = expected_drive.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] drive mismatch: expected %0d got %0d", $realtime,
                   $signed(want), $signed(got));
      end
    endfunction

    function int pending();
      return expected_drive.size();
    endfunction

    function void flush_leftover();
      if (expected_drive.size() != 0) begin
        $display("%0d drive values never came out", expected_drive.size());
        mismatches += expected_drive.size();
        expected_drive.delete();
      end
    endfunction
  endclass

  drive_predictor sb;

  function automatic int pick_gap();
    if ($urandom_range(99, 0) < 85) return $urandom_range(4, 1);
    return $urandom_range(120, 10);
  endfunction

  function automatic int sender_pause();
    if (tx_steady || $urandom_range(2, 0) != 0) return 0;
    return pick_gap();
  endfunction

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(3, 0))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic void pick_sample(output logic [15:0] measured, output logic [15:0] target);
    int sel;
    int tv;
    int dv;
    int mv;
    logic [15:0] r;
    sel = $urandom_range(99, 0);
    r = 16'($urandom);
    tv = $signed(r);
    if (sel >= 85) begin
      measured = pick_edge();
      target = pick_edge();
      return;
    end
    if (sel >= 70) begin
      measured = 16'($urandom);
      target = 16'($urandom);
      return;
    end
    // small errors keep the integrator below the windup limit for a while
    if (sel < 55) dv = int'($urandom_range(600, 0)) - 300;
    else dv = int'($urandom_range(8, 0)) - 4;
    mv = tv - dv;
    if (mv > 32767) mv = 32767;
    if (mv < -32768) mv = -32768;
    measured = mv[15:0];
    target = tv[15:0];
  endfunction

  function automatic logic [15:0] pick_coef(bit extreme);
    int sel;
    int v;
    if (extreme) begin
      case ($urandom_range(4, 0))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        3: return 16'h0001;
        default: return 16'h0000;
      endcase
    end
    sel = $urandom_range(99, 0);
    if (sel < 50) v = int'($urandom_range(32, 0)) - 16;
    else if (sel < 65) v = int'($urandom_range(512, 0)) - 256;
    else if (sel < 90) v = int'($urandom);
    else v = 0;
    return v[15:0];
  endfunction

  function automatic void pick_limits(output logic [15:0] hi, output logic [15:0] lo);
    int sel;
    int a;
    int b;
    logic [15:0] ra;
    logic [15:0] rb;
    sel = $urandom_range(99, 0);
    ra = 16'($urandom);
    rb = 16'($urandom);
    a = $signed(ra);
    b = $signed(rb);
    if (sel < 25) begin
      hi = 16'h7fff;
      lo = 16'h8000;
    end else if (sel < 55) begin
      hi = (a > b) ? ra : rb;
      lo = (a > b) ? rb : ra;
    end else if (sel < 70) begin
      // crossed limits
      hi = (a > b) ? rb : ra;
      lo = (a > b) ? ra : rb;
    end else if (sel < 85) begin
      a = $urandom_range(200, 0);
      b = -int'($urandom_range(200, 0));
      hi = a[15:0];
      lo = b[15:0];
    end else begin
      hi = ra;
      lo = rb;
    end
  endfunction

  task automatic send_sample(input logic [15:0] measured, input logic [15:0] target);
    in_valid <= 1'b1;
    in_measured <= measured;
    in_target <= target;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_unlisted();
    write_reg(prgc_pkg::REG_LOWER + 4'($urandom_range(8, 1)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings();
    logic [3:0] order [8];
    logic [3:0] tmp;
    int j;
    for (int i = 0; i < 8; i++) order[i] = 4'(i);
    for (int i = 7; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < 8; i++) write_reg(order[i], setting[order[i]]);
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic load_gains(input logic [15:0] pn, input logic [15:0] pd,
                            input logic [15:0] inum, input logic [15:0] iden,
                            input logic [15:0] dn, input logic [15:0] dd,
                            input logic [15:0] hi, input logic [15:0] lo);
    setting[prgc_pkg::REG_PROP_NUM]  = pn;
    setting[prgc_pkg::REG_PROP_DEN]  = pd;
    setting[prgc_pkg::REG_INTEG_NUM] = inum;
    setting[prgc_pkg::REG_INTEG_DEN] = iden;
    setting[prgc_pkg::REG_DERIV_NUM] = dn;
    setting[prgc_pkg::REG_DERIV_DEN] = dd;
    setting[prgc_pkg::REG_UPPER]     = hi;
    setting[prgc_pkg::REG_LOWER]     = lo;
    apply_settings();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_sample(in_measured, in_target);
      if (out_valid && out_ready) sb.compare_drive(out_drive);
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        reg_writes++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STALL_LIMIT) begin
          $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
          $display("** pid_rational_gain_controller_unit: FAILED **");
          $finish;
        end
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady && $urandom_range(5, 0) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    logic [15:0] m;
    logic [15:0] t;
    logic [15:0] hi;
    logic [15:0] lo;
    bit extreme;
    int pause_at;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains: every term off, drive stays zero
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h7fff, 16'h8000);
    drain_results();

    // full-scale errors, negative denominator, most negative derivative gain
    load_gains(16'd3, 16'(-2), 16'd5, 16'd3, 16'h8000, 16'd7, 16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h0000, 16'h0000);
    send_sample(16'd1234, 16'd1234);
    drain_results();

    // unlisted index must not restart the derivative history
    write_unlisted();
    send_sample(16'h0000, 16'h7fff);
    send_sample(16'hffff, 16'h8000);
    drain_results();

    // all terms disabled by zero denominators, limits crossed
    load_gains(16'd7, 16'd0, 16'd7, 16'd0, 16'd7, 16'd0, 16'(-5), 16'd5);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'd1, 16'd0);
    drain_results();

    // integrator alone, pushed past the windup limit both ways
    load_gains(16'd0, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 16'h7fff, 16'h8000);
    repeat (5) send_sample(16'd0, 16'd3000);
    repeat (5) send_sample(16'd0, 16'(-3000));
    drain_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      extreme = (ph % 4 == 0);
      setting[prgc_pkg::REG_PROP_NUM]  = pick_coef(extreme);
      setting[prgc_pkg::REG_PROP_DEN]  = pick_coef(extreme);
      setting[prgc_pkg::REG_INTEG_NUM] = pick_coef(extreme);
      setting[prgc_pkg::REG_INTEG_DEN] = pick_coef(extreme);
      setting[prgc_pkg::REG_DERIV_NUM] = pick_coef(extreme);
      setting[prgc_pkg::REG_DERIV_DEN] = pick_coef(extreme);
      pick_limits(hi, lo);
      setting[prgc_pkg::REG_UPPER] = hi;
      setting[prgc_pkg::REG_LOWER] = lo;
      tx_steady = (ph % 4 == 3);
      rx_steady = (ph % 4 == 3) || (ph % 6 == 1);
      apply_settings();
      pause_at = $urandom_range(PHASE_ITEMS - 10, 10);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick_sample(m, t);
        send_sample(m, t);
        if (k == pause_at) begin
          // hold off until the pipeline is empty
          drain_results();
          if (ph % 3 == 1) write_unlisted();
        end else begin
          sender_gap(sender_pause());
        end
      end
      drain_results();
    end

    repeat (100) @(posedge clk);
    sb.flush_leftover();
    $display("covered %0d samples and %0d drive values over %0d gain/limit settings",
             sb.samples, sb.drives_checked, settings_applied);
    $display("%0d register writes, %0d integrator windup clears, %0d mismatches",
             reg_writes, sb.windup_clears, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("** pid_rational_gain_controller_unit: PASSED **");
    end else begin
      $display("** pid_rational_gain_controller_unit: FAILED **");
    end
    $finish;
  end

endmodule
